// ----- rtl/core/vdtd_pkg.sv -----
// Shared types and constants for the display timing and row fetch core.
package vdtd_pkg;

   // Fixed geometry of the display and its timing
   localparam int unsigned ROW_PIXELS      = 64;
   localparam int unsigned LINES_PER_FRAME = 262;
   localparam int unsigned LINE_W          = 9;
   localparam int unsigned CYCLE_W         = 4;
   localparam int unsigned FUNC_W          = 2;
   localparam int unsigned ROW_INDEX_W     = 7;
   localparam int unsigned ROW_BYTES       = ROW_PIXELS / 8;

   // Sync windows, interrupt point, row window and DMA window, in lines and machine cycles
   localparam logic [LINE_W-1:0]  SYNC_A_START = 9'd60;
   localparam logic [LINE_W-1:0]  SYNC_A_END   = 9'd64;
   localparam logic [LINE_W-1:0]  SYNC_B_START = 9'd188;
   localparam logic [LINE_W-1:0]  SYNC_B_END   = 9'd192;
   localparam logic [LINE_W-1:0]  IRQ_LINE     = 9'd62;
   localparam logic [LINE_W-1:0]  ROW_FIRST    = 9'd64;
   localparam logic [LINE_W-1:0]  ROW_LAST     = 9'd191;
   localparam logic [LINE_W-1:0]  FRAME_LINES  = LINE_W'(LINES_PER_FRAME);
   localparam logic [CYCLE_W-1:0] IRQ_CYCLE    = 4'd2;
   localparam logic [CYCLE_W-1:0] DMA_FIRST    = 4'd4;
   localparam logic [CYCLE_W-1:0] DMA_LAST     = 4'd11;
   localparam logic [CYCLE_W-1:0] DMA_END      = 4'd12;
   localparam logic [CYCLE_W-1:0] LAST_CYCLE   = 4'd13;

   // Function codes of one request beat
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_DISP_OFF = 2'd1,
      FUNC_DISP_ON = 2'd2
   } func_type;

   // Timing state carried from beat to beat
   typedef struct packed {
      logic [LINE_W-1:0]  line_count;
      logic [CYCLE_W-1:0] cycle_in_line;
      logic               display_on;
      logic               ef_level;
      logic               frame_interrupted;
   } state_type;

   // One result beat
   typedef struct packed {
      logic                   ef_flag;
      logic                   raise_interrupt;
      logic                   cpu_cycle_taken;
      logic                   row_valid;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [ROW_PIXELS-1:0]  row_pixels;
   } result_type;

endpackage

// ----- rtl/core/vdtd_step.sv -----
// Next-state and result logic for one request beat of the timing core.
module vdtd_step (
   input  vdtd_pkg::state_type               state,
   input  logic [vdtd_pkg::FUNC_W-1:0]       func,
   input  logic [vdtd_pkg::ROW_PIXELS-1:0]   dma_bytes,
   output vdtd_pkg::state_type               state_next,
   output vdtd_pkg::result_type              result
);
   import vdtd_pkg::*;

   logic [LINE_W-1:0]     line_inc;
   logic [LINE_W-1:0]     line_new;
   logic                  ef_new;
   logic                  frame_new;
   logic                  irq_point;
   logic                  burst;
   logic [CYCLE_W-1:0]    cycle_base;
   logic [CYCLE_W-1:0]    cycle_inc;
   logic [ROW_PIXELS-1:0] byte_mask;
   logic [LINE_W-1:0]     row_off;

   // Step the line counter on cycle zero and track the sync windows
   always_comb begin
      line_inc = state.line_count;
      ef_new   = state.ef_level;
      if (state.cycle_in_line == '0) begin
         line_inc = state.line_count + 1'b1;
         if (line_inc == SYNC_A_START) ef_new = 1'b0;
         if (line_inc == SYNC_A_END)   ef_new = 1'b1;
         if (line_inc == SYNC_B_START) ef_new = 1'b0;
         if (line_inc == SYNC_B_END)   ef_new = 1'b1;
      end
      line_new = (line_inc >= FRAME_LINES) ? '0 : line_inc;
   end

   // Arm or disarm the frame at the interrupt point
   assign irq_point = (state.cycle_in_line == IRQ_CYCLE) && (line_new == IRQ_LINE);
   assign frame_new = irq_point ? state.display_on : state.frame_interrupted;

   // Row fetch window
   assign burst = (line_new >= ROW_FIRST) && (line_new <= ROW_LAST) && state.display_on &&
                  frame_new && (state.cycle_in_line >= DMA_FIRST) &&
                  (state.cycle_in_line <= DMA_LAST);

   // Keep only the bytes that fit before cycle twelve, top byte first
   always_comb begin
      for (int b = 0; b < ROW_BYTES; b++) begin
         byte_mask[ROW_PIXELS-1-8*b -: 8] =
            ((CYCLE_W+1)'(b) + {1'b0, state.cycle_in_line} < {1'b0, DMA_END}) ? 8'hFF : 8'h00;
      end
   end

   // Advance the machine cycle, jumping past the burst
   assign cycle_base = burst ? DMA_LAST : state.cycle_in_line;
   assign cycle_inc  = cycle_base + 1'b1;
   assign row_off    = line_new - ROW_FIRST;

   // Select the outcome by function code
   always_comb begin
      state_next = state;
      result     = '0;
      unique case (func)
         FUNC_DISP_OFF: begin
            state_next.display_on = 1'b0;
         end
         FUNC_DISP_ON: begin
            state_next.display_on = 1'b1;
         end
         FUNC_TICK: begin
            state_next.line_count        = line_new;
            state_next.ef_level          = ef_new;
            state_next.frame_interrupted = frame_new;
            state_next.cycle_in_line     = (cycle_inc > LAST_CYCLE) ? '0 : cycle_inc;
            result.raise_interrupt       = irq_point & state.display_on;
            result.cpu_cycle_taken       = (irq_point & state.display_on) | burst;
            result.row_valid             = burst;
            result.row_index             = burst ? row_off[ROW_INDEX_W-1:0] : '0;
            result.row_pixels            = burst ? (dma_bytes & byte_mask) : '0;
         end
         default: begin
            // unused code: hold everything
         end
      endcase
      result.ef_flag = state_next.ef_level;
   end

endmodule

// ----- rtl/core/video_display_timing_dma_core.sv -----
// Display timing generator with DMA row fetch: state and output registers.
// One request beat is taken every clock while the result register is empty
// or being drained in the same cycle; each beat produces one result beat,
// held in the single result register from the following clock. A beat is a
// machine-cycle tick, a display-off port write or a display-on port read.
// Ticks step a machine-cycle counter through 0-13 and a 262-line frame
// counter, pull the flag low on lines 60-63 and 188-191, raise the interrupt
// on line 62 at IRQ_CYCLE when display is on, and on lines 64-191 of an armed
// frame with display on fetch one 64-pixel row from the DMA bytes. No warm-up
// is needed after reset. Throughput is one beat per clock unless output stalls.
module video_display_timing_dma_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [vdtd_pkg::FUNC_W-1:0]          req_func,
   input  logic [vdtd_pkg::ROW_PIXELS-1:0]      req_dma_bytes,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ef_flag,
   output logic                                 rsp_raise_interrupt,
   output logic                                 rsp_cpu_cycle_taken,
   output logic                                 rsp_row_valid,
   output logic [vdtd_pkg::ROW_INDEX_W-1:0]     rsp_row_index,
   output logic [vdtd_pkg::ROW_PIXELS-1:0]      rsp_row_pixels
);
   import vdtd_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   // Take a beat whenever the result register frees up this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   vdtd_step u_step (
      .state      (state_ff),
      .func       (req_func),
      .dma_bytes  (req_dma_bytes),
      .state_next (state_in),
      .result     (result_in)
   );

   // Hold timing state and the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.line_count        <= '0;
         state_ff.cycle_in_line     <= '0;
         state_ff.display_on        <= 1'b0;
         state_ff.ef_level          <= 1'b1;
         state_ff.frame_interrupted <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load payload without reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ef_flag         = rsp_ff.ef_flag;
   assign rsp_raise_interrupt = rsp_ff.raise_interrupt;
   assign rsp_cpu_cycle_taken = rsp_ff.cpu_cycle_taken;
   assign rsp_row_valid       = rsp_ff.row_valid;
   assign rsp_row_index       = rsp_ff.row_index;
   assign rsp_row_pixels      = rsp_ff.row_pixels;

endmodule

// ----- rtl/core/vdtd_checker.sv -----
// Port-level checks on the timing core's result beats, bound to the top level.
module vdtd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_ef_flag,
   input logic                               rsp_raise_interrupt,
   input logic                               rsp_cpu_cycle_taken,
   input logic                               rsp_row_valid,
   input logic [vdtd_pkg::ROW_INDEX_W-1:0]   rsp_row_index,
   input logic [vdtd_pkg::ROW_PIXELS-1:0]    rsp_row_pixels
);
   import vdtd_pkg::*;

   // An interrupt or a row fetch always sets rsp_cpu_cycle_taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_raise_interrupt || rsp_row_valid) |-> rsp_cpu_cycle_taken)
      else $error("cycle steal missing on interrupt or row beat");

   // Interrupt line lies in a sync window, outside the row window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_raise_interrupt |-> !rsp_ef_flag && !rsp_row_valid)
      else $error("interrupt beat outside sync window or with a row");

   // No row fetched: row fields read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_valid |-> (rsp_row_index == '0) && (rsp_row_pixels == '0))
      else $error("row fields nonzero without a row");

   // Hold a stalled result beat and its payload until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_ef_flag, rsp_raise_interrupt, rsp_cpu_cycle_taken,
                  rsp_row_valid, rsp_row_index, rsp_row_pixels}))
      else $error("result beat dropped or changed while stalled");

endmodule

bind video_display_timing_dma_core vdtd_checker u_vdtd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_ef_flag         (rsp_ef_flag),
   .rsp_raise_interrupt (rsp_raise_interrupt),
   .rsp_cpu_cycle_taken (rsp_cpu_cycle_taken),
   .rsp_row_valid       (rsp_row_valid),
   .rsp_row_index       (rsp_row_index),
   .rsp_row_pixels      (rsp_row_pixels)
);
